// ===== rtl/pqt_pkg.sv =====
`timescale 1ns / 1ps
// pqt_pkg: shared constants and types for the point-in-quad test block
// no dependencies; used by point_in_quad_test_top and pqt_checker

package pqt_pkg;

   // default coordinate width, signed two's complement
   // the fraction position cancels in every ratio
   localparam int COORD_WIDTH     = 24;

   // edge tolerance in units of 2^-16 of the barycentric scale
   localparam int TOLERANCE_Q16   = 1;
   localparam int ONE_SHIFT       = 16;

   localparam int CSR_INDEX_WIDTH = 3;

   // register stages from request beat to result beat
   localparam int PIPE_LATENCY    = 6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VERTEX0_X = 3'd0,
      CSR_VERTEX0_Y = 3'd1,
      CSR_VERTEX1_X = 3'd2,
      CSR_VERTEX1_Y = 3'd3,
      CSR_VERTEX2_X = 3'd4,
      CSR_VERTEX2_Y = 3'd5,
      CSR_VERTEX3_X = 3'd6,
      CSR_VERTEX3_Y = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      HALF_NONE   = 2'd0,
      HALF_FIRST  = 2'd1,
      HALF_SECOND = 2'd2
   } half_type;

endpackage

// ===== rtl/point_in_quad_test_top.sv =====
`timescale 1ns / 1ps
// point_in_quad_test_top: pipelined point-in-quadrilateral containment test
// depends on pqt_pkg
//
//   channel   handshake              payload
//   --------  ---------------------  ------------------------------------------
//   request   start && !busy         req_point_x, req_point_y
//   result    rsp_valid (strobe)     rsp_inside_res, rsp_matched_half
//   csr       csr_valid && csr_ready csr_index, csr_wdata
//
// one point per cycle; each result passes through the six register stages:
// offsets, products, cross differences,
// sign fold, tolerance scaling and the final compare
// busy stays low: nothing in the pipe ever holds back a new beat
// reset is synchronous; it zeroes the vertex registers and empties the pipe
// the result side cannot stall, so every result beat is a one-cycle strobe

module point_in_quad_test_top #(
   parameter int COORD_WIDTH = pqt_pkg::COORD_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_WIDTH-1:0]          req_point_x,
   input  logic signed [COORD_WIDTH-1:0]          req_point_y,
   // result channel
   output logic                                   rsp_valid,
   output logic                                   rsp_inside_res,
   output logic [1:0]                             rsp_matched_half,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pqt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic signed [COORD_WIDTH-1:0]          csr_wdata
);

   // difference of two coordinates
   localparam int DW = COORD_WIDTH + 1;
   // product of two differences
   localparam int PW = 2 * DW;
   // cross product, with headroom for its negation
   localparam int CW = PW + 1;
   // sums of two cross products
   localparam int SW = CW + 1;
   // scaled compare terms: shifted by the one point plus the tolerance term
   localparam int TW = SW + pqt_pkg::ONE_SHIFT + 1;
   // the quad splits into two triangles along the vertex 0 to vertex 2 diagonal
   localparam int NTRI = 2;

   // vertex registers, index 0..3
   logic signed [COORD_WIDTH-1:0] vx_ff [4];
   logic signed [COORD_WIDTH-1:0] vy_ff [4];

   logic accept;
   logic [pqt_pkg::PIPE_LATENCY-2:0] vld_ff;

   // stage 1: offsets of the point and of vertices 1..3 from vertex 0
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic signed [DW-1:0] ex_ff [3];
   logic signed [DW-1:0] ey_ff [3];

   // stage 2: partial products per triangle
   logic signed [PW-1:0] pd1_ff [NTRI];
   logic signed [PW-1:0] pd2_ff [NTRI];
   logic signed [PW-1:0] pa1_ff [NTRI];
   logic signed [PW-1:0] pa2_ff [NTRI];
   logic signed [PW-1:0] pb1_ff [NTRI];
   logic signed [PW-1:0] pb2_ff [NTRI];

   // stage 3: doubled area and the two barycentric numerators
   logic signed [CW-1:0] den_ff [NTRI];
   logic signed [CW-1:0] na_ff  [NTRI];
   logic signed [CW-1:0] nb_ff  [NTRI];

   // stage 4: folded so that the area is non-negative
   logic signed [CW-1:0] dn_ff  [NTRI];
   logic signed [CW-1:0] an_ff  [NTRI];
   logic signed [CW-1:0] bn_ff  [NTRI];
   logic [NTRI-1:0]      nz4_ff;

   // stage 5: tolerance term and the third-coordinate margin
   logic signed [TW-1:0] dt_ff  [NTRI];
   logic signed [SW-1:0] dms_ff [NTRI];
   logic signed [CW-1:0] an5_ff [NTRI];
   logic signed [CW-1:0] bn5_ff [NTRI];
   logic [NTRI-1:0]      nz5_ff;

   // stage 6: compares, then the result register
   logic signed [TW-1:0] ta [NTRI];
   logic signed [TW-1:0] tb [NTRI];
   logic signed [TW-1:0] tc [NTRI];
   logic [NTRI-1:0]      hit;

   logic              rsp_valid_ff;
   logic              rsp_inside_res_ff;
   pqt_pkg::half_type rsp_half_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // vertex registers, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (pqt_pkg::csr_index_type'(csr_index))
            pqt_pkg::CSR_VERTEX0_X: vx_ff[0] <= csr_wdata;
            pqt_pkg::CSR_VERTEX0_Y: vy_ff[0] <= csr_wdata;
            pqt_pkg::CSR_VERTEX1_X: vx_ff[1] <= csr_wdata;
            pqt_pkg::CSR_VERTEX1_Y: vy_ff[1] <= csr_wdata;
            pqt_pkg::CSR_VERTEX2_X: vx_ff[2] <= csr_wdata;
            pqt_pkg::CSR_VERTEX2_Y: vy_ff[2] <= csr_wdata;
            pqt_pkg::CSR_VERTEX3_X: vx_ff[3] <= csr_wdata;
            pqt_pkg::CSR_VERTEX3_Y: vy_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[pqt_pkg::PIPE_LATENCY-3:0], accept};
         rsp_valid_ff <= vld_ff[pqt_pkg::PIPE_LATENCY-2];
      end
   end

   // stage 1: offsets; edges are re-taken from the vertex registers every
   // cycle so a rewrite while idle reaches the next point
   always_ff @(posedge clock) begin
      dx_ff <= DW'(req_point_x) - DW'(vx_ff[0]);
      dy_ff <= DW'(req_point_y) - DW'(vy_ff[0]);
      for (int i = 0; i < 3; i++) begin
         ex_ff[i] <= DW'(vx_ff[i+1]) - DW'(vx_ff[0]);
         ey_ff[i] <= DW'(vy_ff[i+1]) - DW'(vy_ff[0]);
      end
   end

   // stage 2: triangle t spans edges t and t+1
   //   area = cross(ea, eb), a = cross(d, eb), b = cross(ea, d)
   always_ff @(posedge clock) begin
      for (int t = 0; t < NTRI; t++) begin
         pd1_ff[t] <= PW'(ex_ff[t]) * PW'(ey_ff[t+1]);
         pd2_ff[t] <= PW'(ey_ff[t]) * PW'(ex_ff[t+1]);
         pa1_ff[t] <= PW'(dx_ff)    * PW'(ey_ff[t+1]);
         pa2_ff[t] <= PW'(dy_ff)    * PW'(ex_ff[t+1]);
         pb1_ff[t] <= PW'(ex_ff[t]) * PW'(dy_ff);
         pb2_ff[t] <= PW'(ey_ff[t]) * PW'(dx_ff);
      end
   end

   // stage 3: cross products
   always_ff @(posedge clock) begin
      for (int t = 0; t < NTRI; t++) begin
         den_ff[t] <= CW'(pd1_ff[t]) - CW'(pd2_ff[t]);
         na_ff[t]  <= CW'(pa1_ff[t]) - CW'(pa2_ff[t]);
         nb_ff[t]  <= CW'(pb1_ff[t]) - CW'(pb2_ff[t]);
      end
   end

   // stage 4: flip all three when the area is negative, so that
   // the ratio compares become plain sign checks
   always_ff @(posedge clock) begin
      for (int t = 0; t < NTRI; t++) begin
         if (den_ff[t][CW-1]) begin
            dn_ff[t] <= -den_ff[t];
            an_ff[t] <= -na_ff[t];
            bn_ff[t] <= -nb_ff[t];
         end else begin
            dn_ff[t] <= den_ff[t];
            an_ff[t] <= na_ff[t];
            bn_ff[t] <= nb_ff[t];
         end
         nz4_ff[t] <= (den_ff[t] != '0);
      end
   end

   // stage 5: tolerance is area * tol, third test is area - (a + b)
   always_ff @(posedge clock) begin
      for (int t = 0; t < NTRI; t++) begin
         dt_ff[t]  <= TW'(dn_ff[t]) * TW'(pqt_pkg::TOLERANCE_Q16);
         dms_ff[t] <= SW'(dn_ff[t]) - (SW'(an_ff[t]) + SW'(bn_ff[t]));
         an5_ff[t] <= an_ff[t];
         bn5_ff[t] <= bn_ff[t];
      end
      nz5_ff <= nz4_ff;
   end

   // stage 6: a >= -tol, b >= -tol, a + b <= 1 + tol, all scaled by area * 2^16
   always_comb begin
      for (int t = 0; t < NTRI; t++) begin
         ta[t]  = (TW'(an5_ff[t]) <<< pqt_pkg::ONE_SHIFT) + dt_ff[t];
         tb[t]  = (TW'(bn5_ff[t]) <<< pqt_pkg::ONE_SHIFT) + dt_ff[t];
         tc[t]  = (TW'(dms_ff[t]) <<< pqt_pkg::ONE_SHIFT) + dt_ff[t];
         // a zero-area triangle never contains the point
         hit[t] = nz5_ff[t] && !ta[t][TW-1] && !tb[t][TW-1] && !tc[t][TW-1];
      end
   end

   // result register; the first triangle wins when both match
   always_ff @(posedge clock) begin
      rsp_inside_res_ff <= |hit;
      priority if (hit[0]) begin
         rsp_half_ff <= pqt_pkg::HALF_FIRST;
      end else if (hit[1]) begin
         rsp_half_ff <= pqt_pkg::HALF_SECOND;
      end else begin
         rsp_half_ff <= pqt_pkg::HALF_NONE;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_inside_res_ff;
   assign rsp_matched_half = rsp_half_ff;

endmodule

// ===== rtl/pqt_checker.sv =====
`timescale 1ns / 1ps
// pqt_port_checker: port-level assertions for point_in_quad_test_top, bound in below
// depends on pqt_pkg

module pqt_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_inside_res,
   input logic [1:0] rsp_matched_half
);

   // every result beat traces back to an earlier request beat
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, pqt_pkg::PIPE_LATENCY))
      else $error("result beat without a matching request beat");

   // a request beat with no reset in between always yields a result beat
   a_no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, pqt_pkg::PIPE_LATENCY) &&
       !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) &&
       !$past(reset, 4) && !$past(reset, 5) && !$past(reset, 6))
      |-> rsp_valid)
      else $error("request beat produced no result beat");

   // a hit names its triangle, a miss names none
   a_half_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_inside_res &&
            (rsp_matched_half == pqt_pkg::HALF_FIRST ||
             rsp_matched_half == pqt_pkg::HALF_SECOND)) ||
         (!rsp_inside_res && rsp_matched_half == pqt_pkg::HALF_NONE))
      else $error("inside flag and matched half disagree");

endmodule

bind point_in_quad_test_top pqt_port_checker u_pqt_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_inside_res   (rsp_inside_res),
   .rsp_matched_half (rsp_matched_half)
);

// ===== test/pqt_checker.sv =====
`timescale 1ns / 1ps
// pqt_checker: scoreboard for point_in_quad_test_top
// mirrors the vertex registers, predicts every result beat and compares it
// depends on pqt_pkg

module pqt_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_inside_res,
   input  logic [1:0]                            rsp_matched_half,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [pqt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] csr_wdata,
   output int                                    pending_results,
   output int                                    mismatches
);

   typedef logic signed [pqt_pkg::COORD_WIDTH-1:0] coord_type;
   typedef logic signed [127:0] acc_type;

   typedef struct packed {
      coord_type          px;
      coord_type          py;
      logic               in_quad;
      pqt_pkg::half_type  half;
   } verdict_type;

   localparam acc_type ONE_SCALE = acc_type'(1) <<< pqt_pkg::ONE_SHIFT;

   coord_type   vertex [8];
   verdict_type awaited_verdicts [$];
   int          mismatch_tally = 0;

   assign mismatches = mismatch_tally;

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatch_tally++;
   endtask

   // exact rational test, scaled through by |area| and 2^16
   function automatic logic point_in_triangle(input acc_type dx, dy, e1x, e1y, e2x, e2y);
      acc_type area, wa, wb;
      area = e1x * e2y - e1y * e2x;
      wa   = dx * e2y - dy * e2x;
      wb   = e1x * dy - e1y * dx;
      if (area == 0)
         return 1'b0;
      if (area < 0) begin
         area = -area;
         wa   = -wa;
         wb   = -wb;
      end
      return (wa * ONE_SCALE + area * pqt_pkg::TOLERANCE_Q16 >= 0)
          && (wb * ONE_SCALE + area * pqt_pkg::TOLERANCE_Q16 >= 0)
          && (area * (ONE_SCALE + pqt_pkg::TOLERANCE_Q16) - (wa + wb) * ONE_SCALE >= 0);
   endfunction

   function automatic verdict_type predict_containment(input coord_type px,
                                                       input coord_type py);
      acc_type     ox, oy, dx, dy, e1x, e1y, e2x, e2y, e3x, e3y;
      verdict_type v;
      ox  = acc_type'(vertex[pqt_pkg::CSR_VERTEX0_X]);
      oy  = acc_type'(vertex[pqt_pkg::CSR_VERTEX0_Y]);
      e1x = acc_type'(vertex[pqt_pkg::CSR_VERTEX1_X]) - ox;
      e1y = acc_type'(vertex[pqt_pkg::CSR_VERTEX1_Y]) - oy;
      e2x = acc_type'(vertex[pqt_pkg::CSR_VERTEX2_X]) - ox;
      e2y = acc_type'(vertex[pqt_pkg::CSR_VERTEX2_Y]) - oy;
      e3x = acc_type'(vertex[pqt_pkg::CSR_VERTEX3_X]) - ox;
      e3y = acc_type'(vertex[pqt_pkg::CSR_VERTEX3_Y]) - oy;
      dx  = acc_type'(px) - ox;
      dy  = acc_type'(py) - oy;
      v.px = px;
      v.py = py;
      // first half wins when the point sits on the shared diagonal
      if (point_in_triangle(dx, dy, e1x, e1y, e2x, e2y)) begin
         v.in_quad = 1'b1;
         v.half    = pqt_pkg::HALF_FIRST;
      end else if (point_in_triangle(dx, dy, e2x, e2y, e3x, e3y)) begin
         v.in_quad = 1'b1;
         v.half    = pqt_pkg::HALF_SECOND;
      end else begin
         v.in_quad = 1'b0;
         v.half    = pqt_pkg::HALF_NONE;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         foreach (vertex[i])
            vertex[i] = '0;
         awaited_verdicts.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_verdicts.size() == 0) begin
               report_mismatch("result beat with no point outstanding");
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_inside_res !== want.in_quad)
                  report_mismatch($sformatf("point (%0d,%0d) inside %b, expected %b",
                     want.px, want.py, rsp_inside_res, want.in_quad));
               if (rsp_matched_half !== want.half)
                  report_mismatch($sformatf("point (%0d,%0d) half %0d, expected %0d",
                     want.px, want.py, rsp_matched_half, want.half));
            end
         end
         // a point sees the vertices as they stood before this edge
         if (start && !busy)
            awaited_verdicts.push_back(predict_containment(req_point_x, req_point_y));
         if (csr_valid && csr_ready)
            vertex[csr_index] = csr_wdata;
      end
      pending_results <= awaited_verdicts.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for point_in_quad_test_top
// depends on pqt_pkg and pqt_checker, which predicts and compares every result beat

module tb_top;

   typedef logic signed [pqt_pkg::COORD_WIDTH-1:0] coord_type;

   localparam longint COORD_MAX   = (longint'(1) <<< (pqt_pkg::COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN   = -(longint'(1) <<< (pqt_pkg::COORD_WIDTH - 1));
   localparam longint SIDE        = 65536;
   localparam longint MID         = 32768;
   localparam int     QUAD_BEATS  = 66;
   localparam int     CYCLE_LIMIT = 200000;

   // all inputs known from time zero
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                start       = 1'b0;
   coord_type                           req_point_x = '0;
   coord_type                           req_point_y = '0;
   logic                                csr_valid   = 1'b0;
   logic [pqt_pkg::CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   coord_type                           csr_wdata   = '0;

   logic                                busy;
   logic                                rsp_valid;
   logic                                rsp_inside_res;
   logic [1:0]                          rsp_matched_half;
   logic                                csr_ready;

   int                                  pending_results;
   int                                  mismatches;
   int unsigned                         cycle_count = 0;

   // vertex set currently being programmed, indexed like the register map
   coord_type                           quad_now [8];

   // sender idle percentage per random phase; the receiver cannot stall,
   // so the receiver phase runs with the sender busy
   int                                  phase_idle [4] = '{0, 51, 0, 36};

   always #5 clock = ~clock;

   point_in_quad_test_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_matched_half (rsp_matched_half),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pqt_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_matched_half (rsp_matched_half),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending_results  (pending_results),
      .mismatches       (mismatches)
   );

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic coord_type clamp_coord(input longint v);
      if (v > COORD_MAX)
         return coord_type'(COORD_MAX);
      if (v < COORD_MIN)
         return coord_type'(COORD_MIN);
      return coord_type'(v);
   endfunction

   // extremes and their neighbors show up far more often than plain random
   function automatic longint pick_coord();
      case ($urandom_range(5))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         3: return -1;
         default: return longint'(coord_type'($urandom));
      endcase
   endfunction

   // idle cycles before the next beat, geometric in the idle percentage
   function automatic int unsigned draw_gap(input int unsigned pct);
      int unsigned g = 0;
      while (g < 24 && $urandom_range(99) < pct)
         g++;
      return g;
   endfunction

   task automatic set_quad(input longint x0, y0, x1, y1, x2, y2, x3, y3);
      quad_now[pqt_pkg::CSR_VERTEX0_X] = clamp_coord(x0);
      quad_now[pqt_pkg::CSR_VERTEX0_Y] = clamp_coord(y0);
      quad_now[pqt_pkg::CSR_VERTEX1_X] = clamp_coord(x1);
      quad_now[pqt_pkg::CSR_VERTEX1_Y] = clamp_coord(y1);
      quad_now[pqt_pkg::CSR_VERTEX2_X] = clamp_coord(x2);
      quad_now[pqt_pkg::CSR_VERTEX2_Y] = clamp_coord(y2);
      quad_now[pqt_pkg::CSR_VERTEX3_X] = clamp_coord(x3);
      quad_now[pqt_pkg::CSR_VERTEX3_Y] = clamp_coord(y3);
   endtask

   // stop sending and wait until every outstanding point has its result beat
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results != 0)
         @(posedge clock);
   endtask

   // one register beat; valid stays high across back-to-back writes
   task automatic write_vertex(input pqt_pkg::csr_index_type idx, input coord_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
   endtask

   // registers only change with the pipe empty; every point yields a result,
   // so an empty scoreboard means an empty pipe
   task automatic program_quad();
      pqt_pkg::csr_index_type r;
      drain_results();
      r = r.first();
      do begin
         write_vertex(r, quad_now[r]);
         r = r.next();
      end while (r != r.first());
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request beat after an optional idle gap; start is lowered once per gap cycle
   task automatic send_point(input longint x, input longint y, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_point_x <= clamp_coord(x);
      req_point_y <= clamp_coord(y);
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   task automatic roll_quad();
      longint cx, cy, rx, ry, sx, sy, xa, xb, ya, yb;
      case ($urandom_range(4))
         0: begin
            // anything goes: bowties, concave shapes, huge areas
            foreach (quad_now[i])
               quad_now[i] = coord_type'($urandom);
         end
         1: begin
            // tiny coordinates so points land exactly on edges often
            foreach (quad_now[i])
               quad_now[i] = coord_type'(int'($urandom_range(128)) - 64);
         end
         2: begin
            // axis-aligned box, corners often at the range limits
            xa = pick_coord();
            xb = pick_coord();
            ya = pick_coord();
            yb = pick_coord();
            set_quad(xa, ya, xb, ya, xb, yb, xa, yb);
         end
         3: begin
            // convex diamond, either winding
            cx = longint'($urandom_range(1 << 23)) - (1 << 22);
            cy = longint'($urandom_range(1 << 23)) - (1 << 22);
            rx = $urandom_range(1, 1 << 21);
            ry = $urandom_range(1, 1 << 21);
            if ($urandom_range(1))
               ry = -ry;
            set_quad(cx - rx, cy, cx, cy - ry, cx + rx, cy, cx, cy + ry);
         end
         default: begin
            // collinear first half, second half collinear or not
            cx = longint'($urandom_range(1 << 21)) - (1 << 20);
            cy = longint'($urandom_range(1 << 21)) - (1 << 20);
            sx = longint'($urandom_range(2048)) - 1024;
            sy = longint'($urandom_range(2048)) - 1024;
            if ($urandom_range(1))
               set_quad(cx, cy, cx + sx, cy + sy, cx + 2 * sx, cy + 2 * sy,
                        cx + 3 * sx, cy + 3 * sy);
            else
               set_quad(cx, cy, cx + sx, cy + sy, cx + 2 * sx, cy + 2 * sy,
                        cx - sy * 3, cy + sx * 3);
         end
      endcase
   endtask

   task automatic roll_point(output longint px, output longint py);
      longint ax, ay, bx, by, lo_x, hi_x, lo_y, hi_y, t;
      int     i, j;
      case ($urandom_range(9))
         0, 1: begin
            px = longint'(coord_type'($urandom));
            py = longint'(coord_type'($urandom));
         end
         2, 3, 4: begin
            // inside the bounding box, where most of the interesting answers are
            lo_x = quad_now[0];
            hi_x = quad_now[0];
            lo_y = quad_now[1];
            hi_y = quad_now[1];
            for (int k = 1; k < 4; k++) begin
               if (quad_now[2 * k] < lo_x) lo_x = quad_now[2 * k];
               if (quad_now[2 * k] > hi_x) hi_x = quad_now[2 * k];
               if (quad_now[2 * k + 1] < lo_y) lo_y = quad_now[2 * k + 1];
               if (quad_now[2 * k + 1] > hi_y) hi_y = quad_now[2 * k + 1];
            end
            px = lo_x + longint'($urandom) % (hi_x - lo_x + 1);
            py = lo_y + longint'($urandom) % (hi_y - lo_y + 1);
         end
         5, 6, 7: begin
            // on or next to an edge or a diagonal
            i  = $urandom_range(3);
            j  = (i + 1 + $urandom_range(2)) % 4;
            t  = $urandom_range(256);
            ax = quad_now[2 * i];
            ay = quad_now[2 * i + 1];
            bx = quad_now[2 * j];
            by = quad_now[2 * j + 1];
            px = ax + (bx - ax) * t / 256 + longint'($urandom_range(4)) - 2;
            py = ay + (by - ay) * t / 256 + longint'($urandom_range(4)) - 2;
         end
         8: begin
            // a vertex, or one lsb away from it
            i  = $urandom_range(3);
            px = longint'(quad_now[2 * i]) + longint'($urandom_range(2)) - 1;
            py = longint'(quad_now[2 * i + 1]) + longint'($urandom_range(2)) - 1;
         end
         default: begin
            px = pick_coord();
            py = pick_coord();
         end
      endcase
   endtask

   initial begin
      longint      px, py;
      int unsigned pct;
      bit          quiet;

      repeat (10)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: every vertex at the origin, so both halves have zero area
      send_point(0, 0, 0);
      send_point(COORD_MAX, COORD_MIN, 0);

      // square of side 1.0 * 2^16 lsb, counterclockwise
      set_quad(0, 0, SIDE, 0, SIDE, SIDE, 0, SIDE);
      program_quad();
      send_point(0, 0, 0);                 // shared vertex
      send_point(SIDE, SIDE, 0);           // far end of the diagonal
      send_point(0, SIDE, 0);              // vertex of the second half only
      send_point(MID, MID, 0);             // on the diagonal, first half wins
      send_point(MID, -1, 0);              // just outside, within tolerance
      send_point(MID, -2, 0);              // just past the tolerance
      send_point(SIDE + 1, MID, 0);        // a+b one tolerance over 1
      send_point(SIDE + 2, MID, 0);        // a+b past the tolerance
      send_point(MID / 2, MID + MID / 2, 0);
      send_point(-1, MID, 0);              // second half within tolerance
      send_point(-2, MID, 0);

      // full-range quad, clockwise so the area sign folds
      set_quad(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MAX, COORD_MIN);
      program_quad();
      send_point(COORD_MIN, COORD_MIN, 0);
      send_point(COORD_MAX, COORD_MAX, 0);
      send_point(COORD_MAX, COORD_MIN, 0);
      send_point(COORD_MIN, COORD_MAX, 0);
      send_point(0, 0, 0);

      // first half collinear, only the second half can match
      set_quad(0, 0, 4096, 4096, 8192, 8192, 0, 8192);
      program_quad();
      send_point(4096, 4096, 0);
      send_point(2048, 6144, 0);
      send_point(6144, 2048, 0);

      // random part: new quads each half phase, bursts without idling inside
      foreach (phase_idle[ph]) begin
         for (int q = 0; q < 2; q++) begin
            roll_quad();
            program_quad();
            quiet = 1'b0;
            for (int n = 0; n < QUAD_BEATS; n++) begin
               if (n % 22 == 0)
                  quiet = ($urandom_range(3) == 0);
               pct = quiet ? 0 : phase_idle[ph];
               roll_point(px, py);
               send_point(px, py, draw_gap(pct));
               // hold off once mid-stream until the pipe has fully emptied
               if (ph == 1 && q == 0 && n == QUAD_BEATS / 2)
                  drain_results();
            end
         end
      end

      drain_results();
      repeat (pqt_pkg::PIPE_LATENCY + 4)
         @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
